FILE: rtl/ucca_pkg.sv
// ----------------------------------------------------------------------------
// ucca_pkg
// Shared types and codes for the unslotted CSMA-CA backoff unit.
// ----------------------------------------------------------------------------
package ucca_pkg;

  // Item kinds
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_CCA   = 2'd2;

  // Result events
  localparam logic [1:0] EV_CCA_REQ = 2'd0;
  localparam logic [1:0] EV_SUCCESS = 2'd1;
  localparam logic [1:0] EV_FAILURE = 2'd2;

  // Access phases
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_BACKOFF  = 2'd1;
  localparam logic [1:0] PH_WAIT_CCA = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_MIN_BE = 2'd0;
  localparam logic [1:0] REG_MAX_BE = 2'd1;
  localparam logic [1:0] REG_MAX_NB = 2'd2;
  localparam logic [1:0] REG_TICKS  = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] random_value;
    logic       channel_clear;
  } ucca_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [3:0] backoff_count;
    logic [3:0] backoff_exponent;
  } ucca_result_t;

  typedef struct packed {
    logic [3:0] min_be;
    logic [3:0] max_be;
    logic [2:0] max_nb;
    logic [7:0] unit_ticks;
  } ucca_cfg_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [3:0] nb;
    logic [3:0] be;
    logic [7:0] units;
    logic [7:0] ticks;
  } ucca_state_t;

endpackage

FILE: rtl/ucca_in_if.sv
// ----------------------------------------------------------------------------
// ucca_in_if / ucca_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface ucca_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] random_value;
  logic       channel_clear;

  modport source (output valid, output mode, output random_value,
                  output channel_clear, input ready);
  modport sink   (input valid, input mode, input random_value,
                  input channel_clear, output ready);
endinterface

interface ucca_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [3:0] backoff_count;
  logic [3:0] backoff_exponent;

  modport source (output valid, output event_res, output backoff_count,
                  output backoff_exponent, input ready);
  modport sink   (input valid, input event_res, input backoff_count,
                  input backoff_exponent, output ready);
endinterface

FILE: rtl/ucca_step.sv
// ----------------------------------------------------------------------------
// ucca_step
// Next-state and event logic for one item of the CSMA-CA engine.
// ----------------------------------------------------------------------------
module ucca_step
  import ucca_pkg::*;
(
  input  ucca_item_t   item,
  input  ucca_state_t  state,
  input  ucca_cfg_t    cfg,
  output ucca_state_t  state_nxt,
  output logic         emit,
  output ucca_result_t res
);

  logic [7:0] unit_ticks;
  logic [3:0] load_be;
  logic [3:0] load_nb;
  logic [7:0] mask;
  logic [7:0] load_units;
  logic [4:0] be_inc;
  logic [3:0] be_sat;
  logic [3:0] nb_inc;
  logic [7:0] ticks_dec;
  logic [7:0] units_dec;

  assign unit_ticks = (cfg.unit_ticks == 8'd0) ? 8'd1 : cfg.unit_ticks;
  assign nb_inc     = state.nb + 4'd1;
  assign be_inc     = {1'b0, state.be} + 5'd1;
  assign be_sat     = (be_inc < {1'b0, cfg.max_be}) ? be_inc[3:0] : cfg.max_be;
  assign ticks_dec  = state.ticks - 8'd1;
  assign units_dec  = state.units - 8'd1;

  // Exponent and count that a fresh backoff is loaded with
  assign load_be = (item.mode == MODE_START) ? cfg.min_be : be_sat;
  assign load_nb = (item.mode == MODE_START) ? 4'd0 : nb_inc;

  always_comb begin
    if (load_be >= 4'd8) begin
      mask = 8'hFF;
    end else begin
      mask = 8'((9'd1 << load_be[2:0]) - 9'd1);
    end
  end
  assign load_units = item.random_value & mask;

  always_comb begin
    state_nxt = state;
    emit      = 1'b0;
    res       = '{event_res: EV_CCA_REQ, backoff_count: state.nb,
                  backoff_exponent: state.be};
    case (item.mode)
      MODE_START, MODE_CCA: begin
        if (item.mode == MODE_START && state.phase == PH_IDLE ||
            item.mode == MODE_CCA && state.phase == PH_WAIT_CCA) begin
          if (item.mode == MODE_CCA && item.channel_clear) begin
            state_nxt.phase = PH_IDLE;
            emit            = 1'b1;
            res.event_res   = EV_SUCCESS;
          end else begin
            state_nxt.nb         = load_nb;
            state_nxt.be         = load_be;
            res.backoff_count    = load_nb;
            res.backoff_exponent = load_be;
            if (item.mode == MODE_CCA && nb_inc > {1'b0, cfg.max_nb}) begin
              state_nxt.phase = PH_IDLE;
              emit            = 1'b1;
              res.event_res   = EV_FAILURE;
            end else begin
              state_nxt.units = load_units;
              if (load_units == 8'd0) begin
                state_nxt.ticks = 8'd0;
                state_nxt.phase = PH_WAIT_CCA;
                emit            = 1'b1;
              end else begin
                state_nxt.ticks = unit_ticks;
                state_nxt.phase = PH_BACKOFF;
              end
            end
          end
        end
      end
      MODE_TICK: begin
        if (state.phase == PH_BACKOFF) begin
          state_nxt.ticks = ticks_dec;
          if (ticks_dec == 8'd0) begin
            state_nxt.units = units_dec;
            if (units_dec != 8'd0) begin
              state_nxt.ticks = unit_ticks;
            end else begin
              state_nxt.phase = PH_WAIT_CCA;
              emit            = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = state;
      end
    endcase
  end

endmodule

FILE: rtl/unslotted_csma_ca_backoff_unit.sv
// ----------------------------------------------------------------------------
// unslotted_csma_ca_backoff_unit
// Unslotted CSMA-CA channel-access engine with random exponential backoff.
// ----------------------------------------------------------------------------
// Flow: the accepting edge loads the input register, and the step result is loaded
//   into the result register once the result register can take a result.
// Throughput: one item per cycle, set by the single-pass step logic; a result
//   stalled by the receiver holds the input once the input register is full.
// Reset: synchronous active-low rst_n empties both registers, returns the
//   engine to idle with zero counts and loads the register defaults.
// ----------------------------------------------------------------------------
module unslotted_csma_ca_backoff_unit
  import ucca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ucca_in_if.sink               in_ch,
  ucca_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  ucca_cfg_t    cfg_r;

  // Input register stage
  logic         s1_valid_r;
  ucca_item_t   s1_item_r;

  // Engine state
  ucca_state_t  state_r;
  ucca_state_t  state_nxt;

  // Result register
  logic         out_valid_r;
  ucca_result_t out_res_r;

  logic         step_emit;
  ucca_result_t step_res;
  logic         s1_go;
  logic         in_take;

  // Process the held item whenever the result register can take a result:
  // it is empty or being drained this cycle.
  assign s1_go   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_take = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{min_be: 4'd3, max_be: 4'd5, max_nb: 3'd4, unit_ticks: 8'd20};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_BE: cfg_r.min_be     <= cfg_data[3:0];
        REG_MAX_BE: cfg_r.max_be     <= cfg_data[3:0];
        REG_MAX_NB: cfg_r.max_nb     <= cfg_data[2:0];
        REG_TICKS:  cfg_r.unit_ticks <= cfg_data;
        default:    cfg_r            <= cfg_r;
      endcase
    end
  end

  // Input register: load on accept, drop once processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= '{mode: in_ch.mode, random_value: in_ch.random_value,
                     channel_clear: in_ch.channel_clear};
    end
  end

  ucca_step u_step (
    .item      (s1_item_r),
    .state     (state_r),
    .cfg       (cfg_r),
    .state_nxt (state_nxt),
    .emit      (step_emit),
    .res       (step_res)
  );

  // Engine state advances only when the held item is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_IDLE, nb: 4'd0, be: 4'd0, units: 8'd0, ticks: 8'd0};
    end else if (s1_go) begin
      state_r <= state_nxt;
    end
  end

  // Result register: hold until taken, refill from the step logic
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= step_emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && step_emit) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.event_res        = out_res_r.event_res;
  assign out_ch.backoff_count    = out_res_r.backoff_count;
  assign out_ch.backoff_exponent = out_res_r.backoff_exponent;

endmodule

FILE: rtl/ucca_checker.sv
// ----------------------------------------------------------------------------
// ucca_checker
// Port-level checks for the unslotted CSMA-CA backoff unit.
// ----------------------------------------------------------------------------
module ucca_checker
  import ucca_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] event_res,
  input logic [3:0] backoff_count,
  input logic [3:0] backoff_exponent
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_res) &&
      $stable(backoff_count) && $stable(backoff_exponent))
    else $error("result changed while stalled");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // A fresh result follows an earlier accepted item
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a preceding item");

  // Failure always follows at least one busy channel
  a_fail_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res == EV_FAILURE |-> backoff_count != 4'd0)
    else $error("failure reported with zero backoff count");

endmodule

bind unslotted_csma_ca_backoff_unit ucca_checker u_ucca_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .event_res        (out_ch.event_res),
  .backoff_count    (out_ch.backoff_count),
  .backoff_exponent (out_ch.backoff_exponent)
);
